@@ design/sre_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Stable rank engine package
// Shared widths, codes, transfer payload types and token type for the cell chain.
// ----------------------------------------------------------------------------
package sre_pkg;

  localparam int MAX_ITEMS = 1024;
  localparam int KEY_BITS  = 32;

  localparam int IDX_W  = $clog2(MAX_ITEMS);
  localparam int CNT_W  = IDX_W + 1;
  localparam int RANK_W = IDX_W;
  localparam int CMP_W  = (CNT_W > 10) ? CNT_W : 10;

  localparam logic [1:0] ACT_LOAD  = 2'd0;
  localparam logic [1:0] ACT_QUERY = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef logic signed [KEY_BITS-1:0] key_t;

  typedef struct packed {
    logic [1:0]         action;
    logic signed [31:0] key_value;
    logic [9:0]         query_index;
  } sre_in_t;

  typedef struct packed {
    logic [9:0] rank;
    logic [1:0] status;
  } sre_out_t;

  typedef enum logic [1:0] {
    TOK_NONE  = 2'd0,
    TOK_LOAD  = 2'd1,
    TOK_QUERY = 2'd2
  } tok_act_e;

  typedef struct packed {
    tok_act_e          act;
    key_t              key;
    logic [IDX_W-1:0]  idx;
    logic [RANK_W-1:0] acc;
    logic [1:0]        status;
  } sre_tok_t;

  function automatic key_t to_key(logic signed [31:0] raw);
    return KEY_BITS'(raw);
  endfunction

endpackage
`default_nettype wire

@@ design/sre_cell.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Stable rank engine cell
// Holds one table entry and passes one token per advance to its neighbor.
// ----------------------------------------------------------------------------
module sre_cell (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    adv_i,
  input  wire logic [sre_pkg::IDX_W-1:0] cell_idx_i,
  input  wire logic                    tok_vld_i,
  input  wire sre_pkg::sre_tok_t       tok_i,
  output logic                         tok_vld_o,
  output sre_pkg::sre_tok_t            tok_o
);
  import sre_pkg::*;

  key_t              key_q, key_d;
  logic [RANK_W-1:0] rank_q, rank_d;
  sre_tok_t          tok_q, tok_d;
  logic              vld_q;

  always_comb begin
    tok_d  = tok_i;
    key_d  = key_q;
    rank_d = rank_q;
    if (tok_vld_i) begin
      case (tok_i.act)
        TOK_LOAD: begin
          if (cell_idx_i == tok_i.idx) begin
            key_d  = tok_i.key;
            rank_d = tok_i.acc;
          end else if (cell_idx_i < tok_i.idx) begin
            if (key_q <= tok_i.key) begin
              tok_d.acc = tok_i.acc + RANK_W'(1);
            end else begin
              rank_d = rank_q + RANK_W'(1);
            end
          end
        end
        TOK_QUERY: begin
          if (cell_idx_i == tok_i.idx) begin
            tok_d.acc = rank_q;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= tok_vld_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      tok_q  <= tok_d;
      key_q  <= key_d;
      rank_q <= rank_d;
    end
  end

  assign tok_vld_o = vld_q;
  assign tok_o     = tok_q;

endmodule
`default_nettype wire

@@ design/stable_rank_engine.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Stable rank engine
// Table of signed keys with stable ascending ranks, built as a chain of cells.
// ----------------------------------------------------------------------------
// The block accepts one transfer per cycle unless the chain holds. Each item
// enters a chain of MAX_ITEMS cells as a token and moves one cell per cycle
// when the chain advances; a load collects its rank from the cells it passes
// and raises the ranks of greater keys, and a query picks up the rank at its
// cell. Results appear in order. The whole chain holds while a result waits
// at the output, so input is refused only in that case.
module stable_rank_engine (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire sre_pkg::sre_in_t  in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output sre_pkg::sre_out_t      out_data_o
);
  import sre_pkg::*;

  logic             adv;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  sre_tok_t         head_tok;
  logic             tok_vld [0:MAX_ITEMS];
  sre_tok_t         tok     [0:MAX_ITEMS];
  logic             out_vld_q;
  sre_out_t         out_q, out_d;
  logic             full;
  logic             range_bad;

  assign adv        = !out_vld_q || out_ready_i;
  assign in_ready_o = adv;

  assign full      = (cnt_q >= CNT_W'(MAX_ITEMS));
  assign range_bad = (CMP_W'(in_data_i.query_index) >= CMP_W'(cnt_q));

  always_comb begin
    head_tok.act    = TOK_NONE;
    head_tok.key    = to_key(in_data_i.key_value);
    head_tok.idx    = cnt_q[IDX_W-1:0];
    head_tok.acc    = '0;
    head_tok.status = ST_OK;
    cnt_d           = cnt_q;
    case (in_data_i.action)
      ACT_LOAD: begin
        if (full) begin
          head_tok.status = ST_FULL;
        end else begin
          head_tok.act = TOK_LOAD;
          cnt_d        = cnt_q + CNT_W'(1);
        end
      end
      ACT_QUERY: begin
        head_tok.idx = IDX_W'(in_data_i.query_index);
        if (range_bad) begin
          head_tok.status = ST_RANGE;
        end else begin
          head_tok.act = TOK_QUERY;
        end
      end
      ACT_CLEAR: begin
        cnt_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (in_valid_i && adv) begin
      cnt_q <= cnt_d;
    end
  end

  assign tok_vld[0] = in_valid_i;
  assign tok[0]     = head_tok;

  for (genvar g = 0; g < MAX_ITEMS; g++) begin : g_cell
    sre_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .adv_i      (adv),
      .cell_idx_i (IDX_W'(g)),
      .tok_vld_i  (tok_vld[g]),
      .tok_i      (tok[g]),
      .tok_vld_o  (tok_vld[g+1]),
      .tok_o      (tok[g+1])
    );
  end

  always_comb begin
    out_d.status = tok[MAX_ITEMS].status;
    out_d.rank   = (tok[MAX_ITEMS].act == TOK_QUERY) ? 10'(tok[MAX_ITEMS].acc) : 10'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= tok_vld[MAX_ITEMS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  a_cnt_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(MAX_ITEMS))
    else $error("entry count exceeds table size");

  a_full_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.action == ACT_LOAD && full) |=> $stable(cnt_q))
    else $error("dropped load changed the entry count");

  a_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && in_data_i.action == ACT_CLEAR) |=> cnt_q == '0)
    else $error("clear did not empty the table");

  a_err_rank : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.status != ST_OK) |-> out_data_o.rank == 10'd0)
    else $error("failed transfer carries a nonzero rank");

endmodule
`default_nettype wire
